FILE: sv/ddcm_pkg.sv
// Shared types and constants for the dual deque card mover.
// No dependencies; imported by every module of the block.
package ddcm_pkg;

  localparam int CARD_W     = 6;
  localparam int DECK_DEPTH = 32;
  localparam int IDX_W      = $clog2(DECK_DEPTH);
  localparam int FILL_W     = $clog2(DECK_DEPTH + 1);
  localparam int MAX_CARDS  = 16;
  localparam int SIZE_W     = 5;
  localparam int RESTART_MAX = (MAX_CARDS < DECK_DEPTH / 2) ? MAX_CARDS : DECK_DEPTH / 2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  localparam int FROM_RIGHT_BIT  = 3;
  localparam int FROM_BOTTOM_BIT = 2;
  localparam int TO_RIGHT_BIT    = 1;
  localparam int TO_BOTTOM_BIT   = 0;

  typedef enum logic [1:0] {
    ACT_MOVE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_DUMP    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_NEXT = 2'd1,
    C_PREV = 2'd2,
    C_LOAD = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    DK_HOLD     = 3'd0,
    DK_POP_TOP  = 3'd1,
    DK_POP_BOT  = 3'd2,
    DK_PUSH_TOP = 3'd3,
    DK_PUSH_BOT = 3'd4,
    DK_ROTATE   = 3'd5,
    DK_RESTART  = 3'd6
  } deck_op_t;

  typedef struct packed {
    deck_op_t          op;
    logic [CARD_W-1:0] card;
  } deck_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PUSH = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  function automatic logic [FILL_W-1:0] restart_count(input logic [SIZE_W-1:0] size);
    logic [FILL_W-1:0] n;
    n = FILL_W'(size);
    if (n > FILL_W'(RESTART_MAX)) begin
      n = FILL_W'(RESTART_MAX);
    end
    return n;
  endfunction

endpackage

FILE: sv/dual_deque_card_mover.sv
// Top level: two card decks built as cell chains, and the action sequencer.
// Depends on ddcm_pkg and ddcm_deck.
// A move pops the source card, then pushes it to the destination; restart and no-op answer from
// idle; a dump enters its dump state, then streams one card per cycle. busy stays high while a move
// or dump is in progress, and no new word is taken while busy; a dump of F cards streams F results.
// Reset: synchronous, active low; both decks empty, deck size 8. Results cannot stall.
module dual_deque_card_mover import ddcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic [3:0]               in_move_code,
  input  logic                     in_deck_select,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  output logic                     out_valid,
  output logic signed [CARD_W-1:0] out_card,
  output logic                     out_moved,
  output logic [FILL_W-1:0]        out_left_count,
  output logic [FILL_W-1:0]        out_right_count,
  output logic                     out_last
);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [CARD_W-1:0] card_r, card_nxt;
  logic              dst_right_r, dst_right_nxt;
  logic              dst_bot_r, dst_bot_nxt;
  logic              sel_r, sel_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;

  logic              emit;
  logic [CARD_W-1:0] emit_card;
  logic              emit_moved;
  logic              emit_last;

  logic              valid_r;
  logic [CARD_W-1:0] ocard_r;
  logic              omoved_r;
  logic [FILL_W-1:0] olcnt_r, orcnt_r;
  logic              olast_r;

  deck_cmd_t         lcmd, rcmd;
  logic [CARD_W-1:0] l_top, l_bot, r_top, r_bot;
  logic [FILL_W-1:0] l_fill, l_fill_nxt, r_fill, r_fill_nxt;
  logic [FILL_W-1:0] size_n;

  logic              src_r, src_b, dst_r, dst_b;
  logic              null_code, full_dst;
  logic [FILL_W-1:0] src_fill, dst_fill, sel_fill;
  action_t           act;

  assign size_n = restart_count(size_r);
  assign act    = action_t'(in_action);
  assign src_r  = in_move_code[FROM_RIGHT_BIT];
  assign src_b  = in_move_code[FROM_BOTTOM_BIT];
  assign dst_r  = in_move_code[TO_RIGHT_BIT];
  assign dst_b  = in_move_code[TO_BOTTOM_BIT];
  assign null_code = (src_r == dst_r) && (src_b == dst_b);
  assign src_fill  = src_r ? r_fill : l_fill;
  assign dst_fill  = dst_r ? r_fill : l_fill;
  assign full_dst  = (src_r != dst_r) && (dst_fill >= FILL_W'(DECK_DEPTH));
  assign sel_fill  = sel_r ? r_fill : l_fill;

  always_comb begin
    state_nxt     = state_r;
    card_nxt      = card_r;
    dst_right_nxt = dst_right_r;
    dst_bot_nxt   = dst_bot_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    lcmd          = '{op: DK_HOLD, card: card_r};
    rcmd          = '{op: DK_HOLD, card: card_r};
    emit          = 1'b0;
    emit_card     = '0;
    emit_moved    = 1'b0;
    emit_last     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority case (act)
            ACT_MOVE: begin
              if (!null_code && (src_fill != '0) && !full_dst) begin
                card_nxt      = src_b ? (src_r ? r_bot : l_bot) : (src_r ? r_top : l_top);
                dst_right_nxt = dst_r;
                dst_bot_nxt   = dst_b;
                if (src_r) begin
                  rcmd.op = src_b ? DK_POP_BOT : DK_POP_TOP;
                end else begin
                  lcmd.op = src_b ? DK_POP_BOT : DK_POP_TOP;
                end
                state_nxt = S_PUSH;
              end else begin
                emit = 1'b1;
              end
            end
            ACT_RESTART: begin
              lcmd.op = DK_RESTART;
              rcmd.op = DK_RESTART;
              emit    = 1'b1;
            end
            ACT_DUMP: begin
              if ((in_deck_select ? r_fill : l_fill) == '0) begin
                emit = 1'b1;
              end else begin
                sel_nxt   = in_deck_select;
                cnt_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_PUSH: begin
        if (dst_right_r) begin
          rcmd.op = dst_bot_r ? DK_PUSH_BOT : DK_PUSH_TOP;
        end else begin
          lcmd.op = dst_bot_r ? DK_PUSH_BOT : DK_PUSH_TOP;
        end
        emit       = 1'b1;
        emit_card  = card_r;
        emit_moved = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DUMP: begin
        if (sel_r) begin
          rcmd.op = DK_ROTATE;
        end else begin
          lcmd.op = DK_ROTATE;
        end
        emit      = 1'b1;
        emit_card = sel_r ? r_top : l_top;
        emit_last = ({1'b0, cnt_r} + FILL_W'(1)) == sel_fill;
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  ddcm_deck u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (lcmd),
    .size_n   (size_n),
    .is_right (1'b0),
    .top_card (l_top),
    .bot_card (l_bot),
    .fill     (l_fill),
    .fill_nxt (l_fill_nxt)
  );

  ddcm_deck u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rcmd),
    .size_n   (size_n),
    .is_right (1'b1),
    .top_card (r_top),
    .bot_card (r_bot),
    .fill     (r_fill),
    .fill_nxt (r_fill_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= SIZE_RESET;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= emit;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    card_r      <= card_nxt;
    dst_right_r <= dst_right_nxt;
    dst_bot_r   <= dst_bot_nxt;
    sel_r       <= sel_nxt;
    cnt_r       <= cnt_nxt;
    ocard_r     <= emit_card;
    omoved_r    <= emit_moved;
    olcnt_r     <= l_fill_nxt;
    orcnt_r     <= r_fill_nxt;
    olast_r     <= emit_last;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = valid_r;
  assign out_card        = ocard_r;
  assign out_moved       = omoved_r;
  assign out_left_count  = olcnt_r;
  assign out_right_count = orcnt_r;
  assign out_last        = olast_r;

endmodule

FILE: sv/ddcm_cell.sv
// One card slot of a deck chain: holds a card, or takes it from a neighbor or a load value.
// Depends on ddcm_pkg.
module ddcm_cell import ddcm_pkg::*; (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [CARD_W-1:0] prev_q,
  input  logic [CARD_W-1:0] next_q,
  input  logic [CARD_W-1:0] load_val,
  output logic [CARD_W-1:0] q
);

  logic [CARD_W-1:0] card_r;
  logic [CARD_W-1:0] card_nxt;

  always_comb begin
    unique case (op)
      C_HOLD: card_nxt = card_r;
      C_NEXT: card_nxt = next_q;
      C_PREV: card_nxt = prev_q;
      C_LOAD: card_nxt = load_val;
      default: card_nxt = card_r;
    endcase
  end

  always_ff @(posedge clk) begin
    card_r <= card_nxt;
  end

  assign q = card_r;

endmodule

FILE: sv/ddcm_deck.sv
// One deck: a row of card cells, top at slot 0, with its fill counter.
// Depends on ddcm_pkg and ddcm_cell.
module ddcm_deck import ddcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  deck_cmd_t         cmd,
  input  logic [FILL_W-1:0] size_n,
  input  logic              is_right,
  output logic [CARD_W-1:0] top_card,
  output logic [CARD_W-1:0] bot_card,
  output logic [FILL_W-1:0] fill,
  output logic [FILL_W-1:0] fill_nxt
);

  logic [CARD_W-1:0] q [DECK_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] bot_pos;

  genvar i;
  generate
    for (i = 0; i < DECK_DEPTH; i++) begin : g_cell
      localparam logic [FILL_W-1:0] POS  = FILL_W'(i);
      localparam logic [FILL_W-1:0] POS1 = FILL_W'(i + 1);
      localparam logic [CARD_W-1:0] UP   = CARD_W'(i + 1);
      cell_op_t          cop;
      logic [CARD_W-1:0] lval;
      logic [CARD_W-1:0] prev_q;
      logic [CARD_W-1:0] next_q;

      assign prev_q = (i == 0) ? q[0] : q[(i == 0) ? 0 : i - 1];
      assign next_q = (i == DECK_DEPTH - 1) ? q[0] : q[(i == DECK_DEPTH - 1) ? 0 : i + 1];

      always_comb begin
        cop  = C_HOLD;
        lval = cmd.card;
        unique case (cmd.op)
          DK_POP_TOP: cop = C_NEXT;
          DK_PUSH_TOP: cop = (i == 0) ? C_LOAD : C_PREV;
          DK_PUSH_BOT: cop = (fill_r == POS) ? C_LOAD : C_HOLD;
          DK_ROTATE: begin
            if (POS1 == fill_r) begin
              cop  = C_LOAD;
              lval = q[0];
            end else if (POS1 < fill_r) begin
              cop = C_NEXT;
            end
          end
          DK_RESTART: begin
            cop  = C_LOAD;
            lval = is_right ? (CARD_W'(0) - UP) : UP;
          end
          default: cop = C_HOLD;
        endcase
      end

      ddcm_cell u_cell (
        .clk      (clk),
        .op       (cop),
        .prev_q   (prev_q),
        .next_q   (next_q),
        .load_val (lval),
        .q        (q[i])
      );
    end
  endgenerate

  always_comb begin
    unique case (cmd.op)
      DK_POP_TOP, DK_POP_BOT:   fill_nxt = fill_r - FILL_W'(1);
      DK_PUSH_TOP, DK_PUSH_BOT: fill_nxt = fill_r + FILL_W'(1);
      DK_RESTART:               fill_nxt = size_n;
      default:                  fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign bot_pos  = fill_r - FILL_W'(1);
  assign top_card = q[0];
  assign bot_card = q[bot_pos[IDX_W-1:0]];
  assign fill     = fill_r;

endmodule

FILE: sv/ddcm_checker.sv
// Port-level checks for the dual deque card mover, bound to the top level.
// Depends on ddcm_pkg and dual_deque_card_mover.
module ddcm_checker import ddcm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [CARD_W-1:0] out_card,
  input logic                     out_moved,
  input logic [FILL_W-1:0]        out_left_count,
  input logic [FILL_W-1:0]        out_right_count,
  input logic                     out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or word after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted word neither answered nor in progress");

  a_move_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> out_last && (out_card != '0))
    else $error("moved word not final or card zero");

  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("dump stream broken");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_count <= FILL_W'(DECK_DEPTH))
                  && (out_right_count <= FILL_W'(DECK_DEPTH)))
    else $error("deck count out of range");

endmodule

bind dual_deque_card_mover ddcm_checker u_ddcm_checker (.*);
